[src/ifas_pkg.sv]
// ----------------------------------------------------------------------------
// ifas_pkg
// Shared types and constants of the bus-slave float add/subtract unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ifas_pkg;

    localparam logic [7:0]  OPCODE_ADD   = 8'd1;
    localparam logic [7:0]  OPCODE_SUB   = 8'd2;
    localparam logic [7:0]  POINTER_MAX  = 8'd3;
    localparam logic [31:0] CONST_RESULT = 32'hBDCEDE62;
    localparam logic [31:0] CANON_NAN    = 32'h7FC00000;

    typedef enum logic [1:0] {
        EV_START = 2'd0,
        EV_WRITE = 2'd1,
        EV_READ  = 2'd2,
        EV_NONE  = 2'd3
    } t_event;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_SUB   = 2'd1,
        OP_CONST = 2'd2
    } t_op;

    typedef struct packed {
        logic        is_read;
        logic        ack;
        logic [1:0]  byte_sel;
        t_op         op;
        logic [31:0] a;
        logic [31:0] b;
    } t_item;

endpackage

`default_nettype wire

[src/i2c_float_add_sub_unit.sv]
// ----------------------------------------------------------------------------
// i2c_float_add_sub_unit
// Bus-slave binary32 add/subtract unit.
//
// Each input item is one bus event (start, write byte, read byte) offered on
// i_opcode/i_write_byte with push, taken when full is low. Every event yields
// one result item, read_byte and ack, shown while empty is low and taken
// with pop. The decoder updates pointer, index and operand registers in the
// cycle it takes an event and queues a snapshot for the arithmetic back end.
// Start, write and no-op events are loaded into the result register at the
// edge they leave the queue, so the back end passes one of them per cycle
// while the result register is free. A read runs the adder: align, add, a
// normalize loop (up to four bit positions per cycle), and round, and then
// loads the result register once it is free.
// New events keep being taken while the back end works until the queue
// (QUEUE_DEPTH entries) is full. When the receiver stalls, the result holds
// and the back end waits, then the queue fills and full goes high.
// Reset clears the bus registers, both operands and the operation code, and
// empties the queue and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_float_add_sub_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [7:0]  i_write_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_read_byte,
    output logic             o_ack
);
    import ifas_pkg::*;

    t_item q_in_item, q_out_item;
    logic  q_push, q_full, q_pop, q_empty;

    assign full = q_full;

    ifas_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_opcode     (i_opcode),
        .i_write_byte (i_write_byte),
        .i_q_full     (q_full),
        .o_q_item     (q_in_item),
        .o_q_push     (q_push)
    );

    ifas_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_item  (q_out_item),
        .o_empty (q_empty)
    );

    ifas_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (q_out_item),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_read_byte (o_read_byte),
        .o_ack       (o_ack)
    );

endmodule

`default_nettype wire

[src/ifas_front.sv]
// ----------------------------------------------------------------------------
// ifas_front
// Bus event decoder: keeps the pointer, index and operand registers and
// hands one classified item per event to the work queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ifas_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [1:0]       i_opcode,
    input  wire logic [7:0]       i_write_byte,
    input  wire logic             i_q_full,
    output ifas_pkg::t_item       o_q_item,
    output logic                  o_q_push
);
    import ifas_pkg::*;

    logic        r_fresh_start, n_fresh_start;
    logic [1:0]  r_reg_pointer, n_reg_pointer;
    logic [1:0]  r_byte_index,  n_byte_index;
    logic [7:0]  r_op_code_reg, n_op_code_reg;
    logic [31:0] r_operand_a,   n_operand_a;
    logic [31:0] r_operand_b,   n_operand_b;
    logic [3:0]  digit_sum;
    logic [2:0]  fold;
    logic [2:0]  mod_a;
    logic [1:0]  mod3;
    logic [1:0]  new_pointer;
    t_event      ev;

    assign ev = t_event'(i_opcode);
    assign o_q_push = i_push && !i_q_full;

    always_comb begin
        digit_sum = 4'(i_write_byte[7:6]) + 4'(i_write_byte[5:4])
                  + 4'(i_write_byte[3:2]) + 4'(i_write_byte[1:0]);
        fold  = 3'(digit_sum[3:2]) + 3'(digit_sum[1:0]);
        mod_a = (fold >= 3'd3) ? fold - 3'd3 : fold;
        mod3  = (mod_a >= 3'd3) ? 2'(mod_a - 3'd3) : mod_a[1:0];
        new_pointer = (i_write_byte > POINTER_MAX) ? mod3 : i_write_byte[1:0];
    end

    always_comb begin
        n_fresh_start = r_fresh_start;
        n_reg_pointer = r_reg_pointer;
        n_byte_index  = r_byte_index;
        n_op_code_reg = r_op_code_reg;
        n_operand_a   = r_operand_a;
        n_operand_b   = r_operand_b;
        unique case (ev)
            EV_START: begin
                n_fresh_start = 1'b1;
            end
            EV_WRITE: begin
                if (r_fresh_start) begin
                    n_reg_pointer = new_pointer;
                    n_byte_index  = 2'd0;
                    n_fresh_start = 1'b0;
                end else if (r_reg_pointer == 2'd0) begin
                    n_op_code_reg = i_write_byte;
                end else if (r_reg_pointer == 2'd1) begin
                    n_operand_a[r_byte_index*8 +: 8] = i_write_byte;
                    n_byte_index = r_byte_index + 2'd1;
                end else if (r_reg_pointer == 2'd2) begin
                    n_operand_b[r_byte_index*8 +: 8] = i_write_byte;
                    n_byte_index = r_byte_index + 2'd1;
                end
            end
            EV_READ: begin
                n_fresh_start = 1'b0;
                n_byte_index  = r_fresh_start ? 2'd0 : r_byte_index + 2'd1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_q_item.is_read  = (ev == EV_READ);
        o_q_item.ack      = (ev != EV_NONE);
        o_q_item.byte_sel = n_byte_index;
        o_q_item.a        = r_operand_a;
        o_q_item.b        = r_operand_b;
        if (r_op_code_reg == OPCODE_ADD) begin
            o_q_item.op = OP_ADD;
        end else if (r_op_code_reg == OPCODE_SUB) begin
            o_q_item.op = OP_SUB;
        end else begin
            o_q_item.op = OP_CONST;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fresh_start <= 1'b0;
            r_reg_pointer <= 2'd0;
            r_byte_index  <= 2'd0;
            r_op_code_reg <= 8'd0;
            r_operand_a   <= 32'd0;
            r_operand_b   <= 32'd0;
        end else if (o_q_push) begin
            r_fresh_start <= n_fresh_start;
            r_reg_pointer <= n_reg_pointer;
            r_byte_index  <= n_byte_index;
            r_op_code_reg <= n_op_code_reg;
            r_operand_a   <= n_operand_a;
            r_operand_b   <= n_operand_b;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push && (ev == EV_START) |=> r_fresh_start)
        else $error("start event did not arm the pointer byte");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push && (ev == EV_READ) |=> !r_fresh_start)
        else $error("read event left the start flag set");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_reg_pointer != 2'd3 || !$past(r_fresh_start) || !$past(o_q_push)
        || $past(ev) != EV_WRITE || $past(i_write_byte) == POINTER_MAX)
        else $error("pointer byte folded to an unreachable register");

endmodule

`default_nettype wire

[src/ifas_queue.sv]
// ----------------------------------------------------------------------------
// ifas_queue
// Small register queue between the bus decoder and the arithmetic back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ifas_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire ifas_pkg::t_item  i_item,
    output logic                  o_full,
    input  wire logic             i_pop,
    output ifas_pkg::t_item       o_item,
    output logic                  o_empty
);
    import ifas_pkg::*;

    localparam int LW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [LW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == LW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue count beyond depth");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> r_wr == r_rd)
        else $error("empty queue with pointers apart");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> r_wr == r_rd)
        else $error("full queue with pointers apart");

endmodule

`default_nettype wire

[src/ifas_back.sv]
// ----------------------------------------------------------------------------
// ifas_back
// Multi-cycle binary32 adder with round to nearest even and the result
// register that drives the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ifas_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ifas_pkg::t_item  i_item,
    input  wire logic             i_q_empty,
    output logic                  o_q_pop,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic [7:0]            o_read_byte,
    output logic                  o_ack
);
    import ifas_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ALIGN = 5'b00010,
        S_ADD   = 5'b00100,
        S_NORM  = 5'b01000,
        S_ROUND = 5'b10000
    } t_state;

    t_state      r_state;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_ack;
    logic [1:0]  r_sel;
    t_op         r_op;
    logic [31:0] r_a, r_b;
    logic        r_nan, r_inf, r_inf_sign, r_zero_sign, r_sign, r_sub;
    logic [26:0] r_mx, r_my;
    logic [27:0] r_sum;
    logic [8:0]  r_e;

    logic        out_free;
    logic        load_out;
    logic        sa, sb, swap;
    logic [7:0]  ea_f, eb_f, ea, eb, e_big, e_small, exp_gap;
    logic [23:0] fa, fb, f_big, f_small;
    logic [26:0] x_small, x_shift, x_mask;
    logic        sticky;
    logic [2:0]  lz, k;
    logic [8:0]  e_lim;
    logic [24:0] m_rnd;
    logic        up;
    logic [8:0]  e_fin;
    logic [23:0] mant;
    logic [31:0] word;

    assign out_free = !r_out_valid || i_pop;
    assign o_empty  = !r_out_valid;
    assign o_read_byte = r_out_byte;
    assign o_ack    = r_out_ack;
    assign o_q_pop  = (r_state == S_IDLE) && !i_q_empty && (i_item.is_read || out_free);
    assign load_out = (o_q_pop && !i_item.is_read) || ((r_state == S_ROUND) && out_free);

    always_comb begin
        sa   = r_a[31];
        sb   = r_b[31] ^ (r_op == OP_SUB);
        ea_f = r_a[30:23];
        eb_f = r_b[30:23];
        ea   = (ea_f == 8'd0) ? 8'd1 : ea_f;
        eb   = (eb_f == 8'd0) ? 8'd1 : eb_f;
        fa   = {ea_f != 8'd0, r_a[22:0]};
        fb   = {eb_f != 8'd0, r_b[22:0]};
        swap = {ea, fa} < {eb, fb};
        e_big   = swap ? eb : ea;
        e_small = swap ? ea : eb;
        f_big   = swap ? fb : fa;
        f_small = swap ? fa : fb;
        exp_gap = e_big - e_small;
        x_small = {f_small, 3'b000};
        if (exp_gap >= 8'd27) begin
            x_shift = 27'd0;
            x_mask  = 27'd0;
            sticky  = |x_small;
        end else begin
            x_shift = x_small >> exp_gap;
            x_mask  = ~(27'h7FFFFFF << exp_gap);
            sticky  = |(x_small & x_mask);
        end
    end

    always_comb begin
        if (r_sum[26]) begin
            lz = 3'd0;
        end else if (r_sum[25]) begin
            lz = 3'd1;
        end else if (r_sum[24]) begin
            lz = 3'd2;
        end else if (r_sum[23]) begin
            lz = 3'd3;
        end else begin
            lz = 3'd4;
        end
        e_lim = r_e - 9'd1;
        k = (9'(lz) > e_lim) ? e_lim[2:0] : lz;
    end

    always_comb begin
        up    = r_sum[2] && (r_sum[1] || r_sum[0] || r_sum[3]);
        m_rnd = {1'b0, r_sum[26:3]} + 25'(up);
        e_fin = r_e + 9'(m_rnd[24]);
        mant  = m_rnd[24] ? m_rnd[24:1] : m_rnd[23:0];
        if (r_op == OP_CONST) begin
            word = CONST_RESULT;
        end else if (r_nan) begin
            word = CANON_NAN;
        end else if (r_inf) begin
            word = {r_inf_sign, 8'hFF, 23'd0};
        end else if (r_sum == 28'd0) begin
            word = {r_zero_sign, 31'd0};
        end else if (e_fin >= 9'd255) begin
            word = {r_sign, 8'hFF, 23'd0};
        end else begin
            word = {r_sign, mant[23] ? e_fin[7:0] : 8'd0, mant[22:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_a   <= i_item.a;
                r_b   <= i_item.b;
                r_op  <= i_item.op;
                r_sel <= i_item.byte_sel;
            end
            S_ALIGN: begin
                r_nan <= (ea_f == 8'hFF && r_a[22:0] != 23'd0)
                      || (eb_f == 8'hFF && r_b[22:0] != 23'd0)
                      || (ea_f == 8'hFF && eb_f == 8'hFF && sa != sb);
                r_inf <= (ea_f == 8'hFF) || (eb_f == 8'hFF);
                r_inf_sign  <= (ea_f == 8'hFF) ? sa : sb;
                r_zero_sign <= sa && sb;
                r_sign <= swap ? sb : sa;
                r_sub  <= sa ^ sb;
                r_mx   <= {f_big, 3'b000};
                r_my   <= {x_shift[26:1], x_shift[0] | sticky};
                r_e    <= 9'(e_big);
            end
            S_ADD: begin
                r_sum <= r_sub ? 28'(r_mx) - 28'(r_my) : 28'(r_mx) + 28'(r_my);
            end
            S_NORM: begin
                if (r_sum[27]) begin
                    r_sum <= {1'b0, r_sum[27:2], r_sum[1] | r_sum[0]};
                    r_e   <= r_e + 9'd1;
                end else if (r_sum != 28'd0 && !r_sum[26] && r_e != 9'd1) begin
                    r_sum <= r_sum << k;
                    r_e   <= r_e - 9'(k);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        if (i_item.is_read) begin
                            r_state <= S_ALIGN;
                        end else begin
                            r_out_byte  <= 8'd0;
                            r_out_ack   <= i_item.ack;
                        end
                    end
                end
                S_ALIGN: r_state <= S_ADD;
                S_ADD:   r_state <= S_NORM;
                S_NORM: begin
                    if (r_sum[27] || r_sum == 28'd0 || r_sum[26] || r_e == 9'd1) begin
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    if (out_free) begin
                        r_out_byte  <= word[r_sel*8 +: 8];
                        r_out_ack   <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_q_pop)
        else $error("queue popped while an item is in flight");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_pop |=> r_out_valid)
        else $error("result dropped without being taken");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NORM) |-> r_e != 9'd0)
        else $error("exponent underflow during normalization");

endmodule

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the bus-slave binary32 add/subtract unit.
// A directed table of bus events comes first, then random event sequences
// that load operands, pick the operation and read the result back, mixed
// with noise and broken sequences. A bit-exact model of the unit predicts
// every result item that the table gives no answer for, and the receiver
// stalls at random and once for a long stretch so that the input queue fills up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import ifas_pkg::*;

    localparam int N_ITEMS        = 550;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int MAX_REPORTS    = 10;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [1:0] i_opcode;
    logic [7:0] i_write_byte;
    logic       empty;
    logic       pop;
    logic [7:0] o_read_byte;
    logic       o_ack;

    i2c_float_add_sub_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_opcode     (i_opcode),
        .i_write_byte (i_write_byte),
        .empty        (empty),
        .pop          (pop),
        .o_read_byte  (o_read_byte),
        .o_ack        (o_ack)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Stimulus table; a row with a typed answer is checked against it.
    t_event     ev_q[$];
    logic [7:0] byte_q[$];
    logic       typed_q[$];
    logic [7:0] typed_rb_q[$];
    logic       typed_ack_q[$];

    logic [7:0] want_rb_q[$];
    logic       want_ack_q[$];

    // Copy of the unit's bus state.
    logic        m_fresh;
    logic [1:0]  m_pointer;
    logic [1:0]  m_index;
    logic [7:0]  m_opcode;
    logic [31:0] m_a;
    logic [31:0] m_b;

    int  errors;
    int  accepted;
    int  idle_cycles;
    bit  stim_done;
    bit  hold_done;

    function automatic logic [31:0] binary32_sum(logic [31:0] x, logic [31:0] y);
        logic        sx;
        logic        sy;
        logic        st;
        int          ex;
        int          ey;
        int          d;
        int          e;
        logic [27:0] mx;
        logic [27:0] my;
        logic [27:0] m;
        logic [24:0] mr;
        logic [31:0] t;
        if ((x[30:23] == 8'hFF && x[22:0] != 0) || (y[30:23] == 8'hFF && y[22:0] != 0))
            return CANON_NAN;
        if (x[30:23] == 8'hFF) begin
            if (y[30:23] == 8'hFF && x[31] != y[31])
                return CANON_NAN;
            return x;
        end
        if (y[30:23] == 8'hFF)
            return y;
        if (y[30:0] > x[30:0]) begin
            t = x;
            x = y;
            y = t;
        end
        sx = x[31];
        sy = y[31];
        ex = (x[30:23] == 0) ? 1 : int'(x[30:23]);
        ey = (y[30:23] == 0) ? 1 : int'(y[30:23]);
        mx = {1'b0, x[30:23] != 0, x[22:0], 3'b000};
        my = {1'b0, y[30:23] != 0, y[22:0], 3'b000};
        d = ex - ey;
        if (d >= 28) begin
            my = {27'd0, my != 0};
        end else begin
            st = (my & ((28'd1 << d) - 28'd1)) != 0;
            my = (my >> d) | {27'd0, st};
        end
        m = (sx == sy) ? mx + my : mx - my;
        if (m == 0)
            return {sx & sy, 31'd0};
        e = ex;
        if (m[27]) begin
            m = (m >> 1) | {27'd0, m[0]};
            e++;
        end else begin
            while (!m[26] && e > 1) begin
                m = m << 1;
                e--;
            end
        end
        mr = {1'b0, m[26:3]};
        if (m[2:0] > 3'd4 || (m[2:0] == 3'd4 && m[3]))
            mr = mr + 25'd1;
        if (mr[24]) begin
            mr = mr >> 1;
            e++;
        end
        if (e >= 255)
            return {sx, 8'hFF, 23'd0};
        return {sx, mr[23] ? 8'(e) : 8'd0, mr[22:0]};
    endfunction

    function automatic logic [31:0] unit_result();
        if (m_opcode == OPCODE_ADD)
            return binary32_sum(m_a, m_b);
        if (m_opcode == OPCODE_SUB)
            return binary32_sum(m_a, {~m_b[31], m_b[30:0]});
        return CONST_RESULT;
    endfunction

    task automatic bus_event_response(input t_event ev, input logic [7:0] data,
                                      output logic [7:0] rb, output logic ack);
        logic [31:0] r;
        rb = 8'd0;
        ack = 1'b1;
        case (ev)
            EV_START: begin
                m_fresh = 1'b1;
            end
            EV_WRITE: begin
                if (m_fresh) begin
                    m_pointer = (data > POINTER_MAX) ? 2'(data % POINTER_MAX)
                                                     : data[1:0];
                    m_index = 2'd0;
                    m_fresh = 1'b0;
                end else if (m_pointer == 2'd0) begin
                    m_opcode = data;
                end else if (m_pointer == 2'd1) begin
                    m_a[m_index*8 +: 8] = data;
                    m_index = m_index + 2'd1;
                end else if (m_pointer == 2'd2) begin
                    m_b[m_index*8 +: 8] = data;
                    m_index = m_index + 2'd1;
                end
            end
            EV_READ: begin
                if (m_fresh) begin
                    m_index = 2'd0;
                    m_fresh = 1'b0;
                end else begin
                    m_index = m_index + 2'd1;
                end
                r = unit_result();
                rb = r[m_index*8 +: 8];
            end
            default: begin
                ack = 1'b0;
            end
        endcase
    endtask

    task automatic add_row(input t_event ev, input logic [7:0] data, input logic typed,
                           input logic [7:0] rb, input logic ack);
        ev_q.push_back(ev);
        byte_q.push_back(data);
        typed_q.push_back(typed);
        typed_rb_q.push_back(rb);
        typed_ack_q.push_back(ack);
    endtask

    task automatic add_event(input t_event ev, input logic [7:0] data);
        add_row(ev, data, 1'b0, 8'd0, 1'b0);
    endtask

    task automatic add_word(input logic [7:0] pointer, input logic [31:0] w);
        add_event(EV_START, 8'($urandom));
        add_event(EV_WRITE, pointer);
        for (int k = 0; k < 4; k++)
            add_event(EV_WRITE, w[k*8 +: 8]);
    endtask

    function automatic logic [31:0] pick_operand(logic [31:0] other);
        logic [31:0] w;
        int          ex;
        w = $urandom;
        case ($urandom_range(0, 7))
            2: begin
                ex = int'(other[30:23]) + $urandom_range(0, 4) - 2;
                if (ex < 0)
                    ex = 0;
                if (ex > 254)
                    ex = 254;
                w[30:23] = 8'(ex);
            end
            3: w[30:23] = 8'h00;
            4: begin
                w[30:23] = 8'hFF;
                if ($urandom_range(0, 1))
                    w[22:0] = 23'd0;
            end
            5: w[30:0] = 31'd0;
            6: w = {$urandom_range(0, 1) ? other[31] : ~other[31], other[30:4], w[3:0]};
            7: w[30:23] = 8'($urandom_range(250, 254));
            default: ;
        endcase
        return w;
    endfunction

    task automatic build_stimulus();
        logic [31:0] a;
        logic [31:0] b;
        add_row(EV_START, 8'h00, 1'b1, 8'h00, 1'b1);
        add_row(EV_READ,  8'h00, 1'b1, CONST_RESULT[7:0],   1'b1);
        add_row(EV_READ,  8'hFF, 1'b1, CONST_RESULT[15:8],  1'b1);
        add_row(EV_READ,  8'h00, 1'b1, CONST_RESULT[23:16], 1'b1);
        add_row(EV_READ,  8'h00, 1'b1, CONST_RESULT[31:24], 1'b1);
        add_row(EV_READ,  8'h00, 1'b1, CONST_RESULT[7:0],   1'b1);
        add_row(EV_NONE,  8'hFF, 1'b1, 8'h00, 1'b0);
        add_row(EV_START, 8'h00, 1'b1, 8'h00, 1'b1);
        add_row(EV_WRITE, 8'h01, 1'b1, 8'h00, 1'b1);
        add_row(EV_WRITE, 8'hFF, 1'b1, 8'h00, 1'b1);
        add_row(EV_WRITE, 8'hFF, 1'b1, 8'h00, 1'b1);
        add_row(EV_WRITE, 8'h7F, 1'b1, 8'h00, 1'b1);
        add_row(EV_WRITE, 8'h7F, 1'b1, 8'h00, 1'b1);
        add_word(8'd2, 32'h7F7FFFFF);
        add_word(8'hFF, 32'h0000_0001);
        add_event(EV_START, 8'h00);
        add_event(EV_READ, 8'h00);
        add_event(EV_READ, 8'h00);
        add_event(EV_START, 8'h00);
        add_event(EV_WRITE, 8'h03);
        add_event(EV_WRITE, 8'hAA);
        add_event(EV_READ, 8'h00);
        add_word(8'd0, 32'h0000_0002);
        add_event(EV_READ, 8'h00);
        a = 32'd0;
        b = 32'd0;
        while (ev_q.size() < N_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    if ($urandom_range(0, 3) != 0) begin
                        a = pick_operand(b);
                        add_word(8'd1, a);
                    end
                    if ($urandom_range(0, 3) != 0) begin
                        b = pick_operand(a);
                        add_word(8'd2, b);
                    end
                    add_event(EV_START, 8'($urandom));
                    add_event(EV_WRITE, 8'd0);
                    add_event(EV_WRITE, ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                        : 8'($urandom_range(1, 2)));
                    add_event(EV_START, 8'($urandom));
                    repeat ($urandom_range(1, 5))
                        add_event(EV_READ, 8'($urandom));
                end
                6: begin
                    add_event(EV_START, 8'($urandom));
                    add_event(EV_WRITE, 8'($urandom));
                    repeat ($urandom_range(0, 3))
                        add_event(EV_WRITE, 8'($urandom));
                end
                7: begin
                    repeat ($urandom_range(1, 4))
                        add_event(t_event'($urandom_range(0, 3)), 8'($urandom));
                end
                default: begin
                    add_event(EV_START, 8'($urandom));
                    add_event(EV_WRITE, 8'($urandom_range(1, 2)));
                    repeat ($urandom_range(1, 3))
                        add_event(EV_WRITE, 8'($urandom));
                    add_event(EV_READ, 8'($urandom));
                end
            endcase
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        push = 1'b0;
        i_opcode = EV_START;
        i_write_byte = 8'd0;
        m_fresh = 1'b0;
        m_pointer = 2'd0;
        m_index = 2'd0;
        m_opcode = 8'd0;
        m_a = 32'd0;
        m_b = 32'd0;
        build_stimulus();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int n = 0; n < ev_q.size(); ) begin
            repeat ($urandom_range(1, 24)) begin
                if (n < ev_q.size()) begin
                    @(negedge i_clk);
                    push <= 1'b1;
                    i_opcode <= ev_q[n];
                    i_write_byte <= byte_q[n];
                    do
                        @(posedge i_clk);
                    while (full);
                    n++;
                end
            end
            if ($urandom_range(0, 2) != 0) begin
                @(negedge i_clk);
                push <= 1'b0;
                i_opcode <= 2'($urandom);
                i_write_byte <= 8'($urandom);
                repeat ($urandom_range(0, 8))
                    @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        push <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        pop = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!hold_done && accepted >= 250) begin
                @(negedge i_clk);
                pop <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(negedge i_clk);
                hold_done = 1'b1;
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        repeat ($urandom_range(8, 64)) begin
                            @(negedge i_clk);
                            pop <= 1'b1;
                        end
                    end
                    1: begin
                        repeat ($urandom_range(8, 64)) begin
                            @(negedge i_clk);
                            pop <= ($urandom_range(0, 3) == 0);
                        end
                    end
                    default: begin
                        repeat ($urandom_range(8, 64)) begin
                            @(negedge i_clk);
                            pop <= 1'($urandom_range(0, 1));
                        end
                    end
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        logic [7:0] rb;
        logic       ack;
        logic [7:0] want_rb;
        logic       want_ack;
        if (i_rst_n) begin
            idle_cycles++;
            if (push && !full) begin
                idle_cycles = 0;
                bus_event_response(t_event'(i_opcode), i_write_byte, rb, ack);
                if (typed_q[accepted]) begin
                    rb = typed_rb_q[accepted];
                    ack = typed_ack_q[accepted];
                end
                want_rb_q.push_back(rb);
                want_ack_q.push_back(ack);
                accepted++;
            end
            if (pop && !empty) begin
                idle_cycles = 0;
                if (want_rb_q.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("unexpected result item: read_byte %02h ack %0d",
                                 o_read_byte, o_ack);
                end else begin
                    want_rb = want_rb_q.pop_front();
                    want_ack = want_ack_q.pop_front();
                    if (o_read_byte !== want_rb || o_ack !== want_ack) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("mismatch: read_byte %02h ack %0d, expected %02h ack %0d",
                                     o_read_byte, o_ack, want_rb, want_ack);
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("** i2c_float_add_sub_unit: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        errors = 0;
        accepted = 0;
        idle_cycles = 0;
        stim_done = 1'b0;
        hold_done = 1'b0;
        @(posedge i_rst_n);
        while (!stim_done || want_rb_q.size() != 0)
            @(posedge i_clk);
        repeat (30)
            @(posedge i_clk);
        if (errors == 0) begin
            $display("** i2c_float_add_sub_unit: PASSED **");
        end else begin
            $display("** i2c_float_add_sub_unit: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire

[i2c_float_add_sub_unit.f]
src/ifas_pkg.sv
src/ifas_front.sv
src/ifas_queue.sv
src/ifas_back.sv
src/i2c_float_add_sub_unit.sv
tb/tb.sv
